// File: sv/lzom_pkg.sv
// Shared constants, codes and types for the layer z-order manager.
package lzom_pkg;

  localparam int LAYER_COUNT = 256;
  localparam int ID_W        = $clog2(LAYER_COUNT);
  localparam int CNT_W       = $clog2(LAYER_COUNT + 1);
  localparam int LAYER_ID_W  = 8;
  localparam int HEIGHT_W    = 9;
  localparam int REQ_W       = 2;
  localparam int STATUS_W    = 2;

  localparam logic signed [HEIGHT_W-1:0] HIDDEN = -9'sd1;

  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SET   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_SLOT  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_USED = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_SHIFT,
    ST_FIN,
    ST_DONE
  } lzom_state_t;

endpackage

// File: sv/lzom_ram.sv
// Generic one-write, one-read memory with registered read data.
module lzom_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/layer_z_order_manager_top.sv
// Layer z-order manager: slot pool, per-slot heights and height-ordered stack.
//
//   channel  direction  ports
//   in       input      in_valid, in_stall, in_req_type, in_layer_id, in_wanted_height
//   out      output     out_valid, out_stall, out_status, out_result_layer,
//                       out_final_height, out_top_height
//
// Allocate scans the slots in order for a free one and reports no slot when none is free.
// Set height and free move each stack entry in between by one place (at most LAYER_COUNT - 1);
// the move streams one stack memory read and one write each cycle.
// Reset clears the in-use marks and hides the stack; the memories need no clearing.
// One transaction at a time: in_stall is high from acceptance until the result is
// handed to the output register, which holds it while out_stall is high.
module layer_z_order_manager_top
  import lzom_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [REQ_W-1:0]           in_req_type,
  input  logic [LAYER_ID_W-1:0]      in_layer_id,
  input  logic signed [HEIGHT_W-1:0] in_wanted_height,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATUS_W-1:0]        out_status,
  output logic [LAYER_ID_W-1:0]      out_result_layer,
  output logic signed [HEIGHT_W-1:0] out_final_height,
  output logic signed [HEIGHT_W-1:0] out_top_height
);

  localparam logic signed [HEIGHT_W:0] ZERO_W = '0;
  localparam logic signed [HEIGHT_W:0] ONE_W  = 10'sd1;
  localparam logic signed [HEIGHT_W:0] HID_W  = -10'sd1;

  lzom_state_t state_r, state_nxt;

  logic [LAYER_COUNT-1:0]       in_use_r, in_use_nxt;
  logic signed [HEIGHT_W-1:0]   top_r, top_nxt;
  logic [REQ_W-1:0]             req_r, req_nxt;
  logic [LAYER_ID_W-1:0]        layer_r, layer_nxt;
  logic signed [HEIGHT_W-1:0]   want_r, want_nxt;
  logic [STATUS_W-1:0]          stat_r, stat_nxt;
  logic signed [HEIGHT_W-1:0]   fin_r, fin_nxt;
  logic [CNT_W-1:0]             scan_r, scan_nxt;
  logic                         up_r, up_nxt;
  logic [ID_W-1:0]              src_r, src_nxt;
  logic [CNT_W-1:0]             rd_left_r, rd_left_nxt;
  logic                         pend_r, pend_nxt;
  logic [ID_W-1:0]              pdst_r, pdst_nxt;
  logic                         place_r, place_nxt;
  logic                         top_inc_r, top_inc_nxt;
  logic                         top_dec_r, top_dec_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]          out_status_r, out_status_nxt;
  logic [LAYER_ID_W-1:0]        out_layer_r, out_layer_nxt;
  logic signed [HEIGHT_W-1:0]   out_fin_r, out_fin_nxt;
  logic signed [HEIGHT_W-1:0]   out_top_r, out_top_nxt;

  // memory ports
  logic                h_we, h_re;
  logic [ID_W-1:0]     h_waddr, h_raddr;
  logic [HEIGHT_W-1:0] h_wdata, h_rdata;
  logic                s_we, s_re;
  logic [ID_W-1:0]     s_waddr, s_raddr;
  logic [ID_W-1:0]     s_wdata, s_rdata;

  logic                     in_acc;
  logic                     id_ok;
  logic                     out_load;
  logic signed [HEIGHT_W:0] old_s, top_s, want_s, limit_s, wc_s, src_s, n_s;

  lzom_ram #(.WIDTH(HEIGHT_W), .DEPTH(LAYER_COUNT)) u_height_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .re    (h_re),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  lzom_ram #(.WIDTH(ID_W), .DEPTH(LAYER_COUNT)) u_stack_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign id_ok    = ({1'b0, in_layer_id} < (LAYER_ID_W + 1)'(LAYER_COUNT)) &&
                    in_use_r[in_layer_id[ID_W-1:0]];
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // clamp arithmetic, one bit wider than the height fields
  always_comb begin
    old_s  = signed'({h_rdata[HEIGHT_W-1], h_rdata});
    top_s  = signed'({top_r[HEIGHT_W-1], top_r});
    want_s = (req_r == REQ_FREE) ? HID_W : signed'({want_r[HEIGHT_W-1], want_r});
    limit_s = (old_s >= ZERO_W) ? top_s : top_s + ONE_W;
    if (want_s > limit_s) begin
      wc_s = limit_s;
    end else if (want_s < HID_W) begin
      wc_s = HID_W;
    end else begin
      wc_s = want_s;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_use_nxt    = in_use_r;
    top_nxt       = top_r;
    req_nxt       = req_r;
    layer_nxt     = layer_r;
    want_nxt      = want_r;
    stat_nxt      = stat_r;
    fin_nxt       = fin_r;
    scan_nxt      = scan_r;
    up_nxt        = up_r;
    src_nxt       = src_r;
    rd_left_nxt   = rd_left_r;
    pend_nxt      = pend_r;
    pdst_nxt      = pdst_r;
    place_nxt     = place_r;
    top_inc_nxt   = top_inc_r;
    top_dec_nxt   = top_dec_r;
    out_valid_nxt = out_valid_r;
    out_status_nxt = out_status_r;
    out_layer_nxt = out_layer_r;
    out_fin_nxt   = out_fin_r;
    out_top_nxt   = out_top_r;
    h_we    = 1'b0;
    h_waddr = '0;
    h_wdata = '0;
    h_re    = 1'b0;
    h_raddr = in_layer_id[ID_W-1:0];
    s_we    = 1'b0;
    s_waddr = '0;
    s_wdata = '0;
    s_re    = 1'b0;
    s_raddr = src_r;
    src_s   = '0;
    n_s     = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          h_re      = 1'b1;
          req_nxt   = in_req_type;
          layer_nxt = in_layer_id;
          want_nxt  = in_wanted_height;
          fin_nxt   = HIDDEN;
          stat_nxt  = STAT_OK;
          case (in_req_type)
            REQ_ALLOC: begin
              scan_nxt  = '0;
              state_nxt = ST_SCAN;
            end
            REQ_SET, REQ_FREE: begin
              if (id_ok) begin
                state_nxt = ST_CALC;
              end else begin
                stat_nxt  = STAT_NOT_USED;
                state_nxt = ST_DONE;
              end
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (scan_r == CNT_W'(LAYER_COUNT)) begin
          stat_nxt  = STAT_NO_SLOT;
          layer_nxt = '0;
          state_nxt = ST_DONE;
        end else if (!in_use_r[scan_r[ID_W-1:0]]) begin
          in_use_nxt[scan_r[ID_W-1:0]] = 1'b1;
          h_we      = 1'b1;
          h_waddr   = scan_r[ID_W-1:0];
          h_wdata   = HIDDEN;
          layer_nxt = LAYER_ID_W'(scan_r[ID_W-1:0]);
          state_nxt = ST_DONE;
        end else begin
          scan_nxt = scan_r + CNT_W'(1);
        end
      end

      ST_CALC: begin
        // old height is on the memory output now
        h_we        = 1'b1;
        h_waddr     = layer_r[ID_W-1:0];
        h_wdata     = wc_s[HEIGHT_W-1:0];
        fin_nxt     = wc_s[HEIGHT_W-1:0];
        up_nxt      = 1'b0;
        place_nxt   = 1'b0;
        top_inc_nxt = 1'b0;
        top_dec_nxt = 1'b0;
        if (old_s > wc_s) begin
          if (wc_s >= ZERO_W) begin
            // lift the entries between new and old height by one place
            up_nxt    = 1'b1;
            src_s     = old_s - ONE_W;
            n_s       = old_s - wc_s;
            place_nxt = 1'b1;
          end else begin
            // hide: drop everything above the old height
            src_s       = old_s + ONE_W;
            n_s         = top_s - old_s;
            top_dec_nxt = 1'b1;
          end
        end else if (old_s < wc_s) begin
          place_nxt = 1'b1;
          if (old_s >= ZERO_W) begin
            src_s = old_s + ONE_W;
            n_s   = wc_s - old_s;
          end else begin
            // show a hidden layer: lift from the top down to the new height
            up_nxt      = 1'b1;
            src_s       = top_s;
            n_s         = top_s - wc_s + ONE_W;
            top_inc_nxt = 1'b1;
          end
        end
        src_nxt     = src_s[ID_W-1:0];
        rd_left_nxt = n_s[CNT_W-1:0];
        pend_nxt    = 1'b0;
        state_nxt   = ST_SHIFT;
      end

      ST_SHIFT: begin
        // reads run ahead of writes in the shift direction, so no entry is
        // read after it is written
        if (pend_r) begin
          s_we    = 1'b1;
          s_waddr = pdst_r;
          s_wdata = s_rdata;
          h_we    = 1'b1;
          h_waddr = s_rdata;
          h_wdata = HEIGHT_W'(pdst_r);
        end
        if (rd_left_r != '0) begin
          s_re        = 1'b1;
          pend_nxt    = 1'b1;
          pdst_nxt    = up_r ? src_r + ID_W'(1) : src_r - ID_W'(1);
          src_nxt     = up_r ? src_r - ID_W'(1) : src_r + ID_W'(1);
          rd_left_nxt = rd_left_r - CNT_W'(1);
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        if (place_r) begin
          s_we    = 1'b1;
          s_waddr = fin_r[ID_W-1:0];
          s_wdata = layer_r[ID_W-1:0];
        end
        if (top_inc_r) begin
          top_nxt = top_r + 9'sd1;
        end else if (top_dec_r) begin
          top_nxt = top_r - 9'sd1;
        end
        if (req_r == REQ_FREE) begin
          in_use_nxt[layer_r[ID_W-1:0]] = 1'b0;
          fin_nxt = HIDDEN;
        end
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat_r;
          out_layer_nxt  = layer_r;
          out_fin_nxt    = fin_r;
          out_top_nxt    = top_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_use_r    <= '0;
      top_r       <= HIDDEN;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_use_r    <= in_use_nxt;
      top_r       <= top_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    layer_r      <= layer_nxt;
    want_r       <= want_nxt;
    stat_r       <= stat_nxt;
    fin_r        <= fin_nxt;
    scan_r       <= scan_nxt;
    up_r         <= up_nxt;
    src_r        <= src_nxt;
    rd_left_r    <= rd_left_nxt;
    pdst_r       <= pdst_nxt;
    place_r      <= place_nxt;
    top_inc_r    <= top_inc_nxt;
    top_dec_r    <= top_dec_nxt;
    out_status_r <= out_status_nxt;
    out_layer_r  <= out_layer_nxt;
    out_fin_r    <= out_fin_nxt;
    out_top_r    <= out_top_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_layer = out_layer_r;
  assign out_final_height = out_fin_r;
  assign out_top_height   = out_top_r;

`ifndef NO_ASSERTIONS
  a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
    top_r >= HIDDEN)
    else $error("stack top below hidden");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != ST_IDLE)
    else $error("accepted transaction not taken up");

  a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && $stable(state_r) == 1'b0)
    else $error("result not presented after load");

  a_no_slot_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && stat_r == STAT_NO_SLOT) |-> &in_use_r)
    else $error("no-slot status while a slot is free");

  a_shift_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    rd_left_r <= CNT_W'(LAYER_COUNT) || state_r != ST_SHIFT)
    else $error("shift count out of range");
`endif

endmodule
